FILE: rtl/core/wide_restoring_divider_defines.svh
// Assertion macros for the wide restoring divider.
// Included by the RTL modules that carry concurrent checks; expects clock and reset in scope.
`ifndef WIDE_RESTORING_DIVIDER_DEFINES_SVH
`define WIDE_RESTORING_DIVIDER_DEFINES_SVH

// same-cycle implication
`define WRD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define WRD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/wrd_pkg.sv
// Shared constants, payload types and state encoding for the wide restoring divider.
// No dependencies; used by the interfaces, wrd_divcore and wide_restoring_divider.
package wrd_pkg;

   localparam int WORDS  = 8;
   localparam int WORD_W = 32;
   localparam int OP_W   = WORDS * WORD_W;
   localparam int POS_W  = $clog2(WORDS + 1);
   localparam int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int BIT_W  = $clog2(OP_W);

   localparam logic [POS_W-1:0]  WORDS_POS = POS_W'(WORDS);
   localparam logic [WIDX_W-1:0] LAST_WIDX = WIDX_W'(WORDS - 1);
   localparam logic [BIT_W-1:0]  LAST_BIT  = BIT_W'(OP_W - 1);

   typedef struct packed {
      logic [WORD_W-1:0] dividend_word;
      logic [WORD_W-1:0] divisor_word;
      logic              final_word;
   } req_payload_type;

   typedef struct packed {
      logic [WORD_W-1:0] quotient_word;
      logic [WORD_W-1:0] remainder_word;
      logic              end_of_result;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

endpackage

FILE: rtl/core/wrd_stream_if.sv
// Valid/ready stream interfaces for the operand and result channels.
// Depends on wrd_pkg for the payload types.
interface wrd_req_if;
   logic                     valid;
   logic                     ready;
   wrd_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface wrd_rsp_if;
   logic                     valid;
   logic                     ready;
   wrd_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/wrd_divcore.sv
// Word-serial restoring division engine plus result drain.
// Depends on wrd_pkg, wrd_rsp_if and wide_restoring_divider_defines.svh.
`include "wide_restoring_divider_defines.svh"

module wrd_divcore (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start_op,
   input  logic [wrd_pkg::OP_W-1:0] num_in,
   input  logic [wrd_pkg::OP_W-1:0] den_in,
   output logic                     idle,
   wrd_rsp_if.source                rsp
);

   wrd_pkg::state_type state_ff, state_in;

   logic [wrd_pkg::OP_W-1:0]   num_ff, num_ff_in;
   logic [wrd_pkg::OP_W-1:0]   den_ff, den_ff_in;
   logic [wrd_pkg::OP_W-1:0]   rem_ff, rem_ff_in;
   logic [wrd_pkg::OP_W-1:0]   quo_ff, quo_ff_in;
   logic [wrd_pkg::OP_W-1:0]   shf_ff, shf_ff_in;
   logic [wrd_pkg::OP_W-1:0]   dif_ff, dif_ff_in;
   logic [wrd_pkg::WIDX_W-1:0] wrd_idx_ff, wrd_idx_in;
   logic [wrd_pkg::BIT_W-1:0]  bit_cnt_ff, bit_cnt_in;
   logic                       shl_carry_ff, shl_carry_in;
   logic                       borrow_ff, borrow_in;

   logic [wrd_pkg::WORD_W-1:0] rem_w;
   logic [wrd_pkg::WORD_W-1:0] den_w;
   logic [wrd_pkg::WORD_W-1:0] shifted;
   logic [wrd_pkg::WORD_W:0]   sub;
   logic                       first_step;
   logic                       last_step;
   logic                       cin;
   logic                       bin;
   logic                       take;
   logic                       last_bit;
   logic                       rsp_xfer;

   // one word of the shift-and-subtract per cycle
   always_comb begin
      rem_w      = rem_ff[wrd_pkg::WORD_W-1:0];
      den_w      = den_ff[wrd_pkg::WORD_W-1:0];
      first_step = (wrd_idx_ff == '0);
      last_step  = (wrd_idx_ff == wrd_pkg::LAST_WIDX);
      last_bit   = (bit_cnt_ff == '0);
      cin        = first_step ? num_ff[wrd_pkg::OP_W-1] : shl_carry_ff;
      bin        = first_step ? 1'b0 : borrow_ff;
      shifted    = {rem_w[wrd_pkg::WORD_W-2:0], cin};
      sub        = {1'b0, shifted} - {1'b0, den_w} - {{wrd_pkg::WORD_W{1'b0}}, bin};
      // bit leaving the top of the remainder forces the subtract
      take       = rem_w[wrd_pkg::WORD_W-1] | ~sub[wrd_pkg::WORD_W];
      rsp_xfer   = rsp.valid & rsp.ready;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wrd_pkg::ST_IDLE: begin
            if (start_op) state_in = wrd_pkg::ST_RUN;
         end
         wrd_pkg::ST_RUN: begin
            if (last_step && last_bit) state_in = wrd_pkg::ST_DRAIN;
         end
         wrd_pkg::ST_DRAIN: begin
            if (rsp_xfer && last_step) state_in = wrd_pkg::ST_IDLE;
         end
         default: state_in = wrd_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      idle      = (state_ff == wrd_pkg::ST_IDLE);
      rsp.valid = (state_ff == wrd_pkg::ST_DRAIN);
      rsp.payload.quotient_word  = quo_ff[wrd_pkg::WORD_W-1:0];
      rsp.payload.remainder_word = rem_ff[wrd_pkg::WORD_W-1:0];
      rsp.payload.end_of_result  = last_step;
   end

   // datapath
   always_comb begin
      num_ff_in    = num_ff;
      den_ff_in    = den_ff;
      rem_ff_in    = rem_ff;
      quo_ff_in    = quo_ff;
      shf_ff_in    = shf_ff;
      dif_ff_in    = dif_ff;
      wrd_idx_in   = wrd_idx_ff;
      bit_cnt_in   = bit_cnt_ff;
      shl_carry_in = shl_carry_ff;
      borrow_in    = borrow_ff;
      unique case (state_ff)
         wrd_pkg::ST_IDLE: begin
            if (start_op) begin
               num_ff_in  = num_in;
               den_ff_in  = den_in;
               rem_ff_in  = '0;
               quo_ff_in  = '0;
               wrd_idx_in = '0;
               bit_cnt_in = wrd_pkg::LAST_BIT;
            end
         end
         wrd_pkg::ST_RUN: begin
            den_ff_in    = (den_ff >> wrd_pkg::WORD_W)
                         | ({{(wrd_pkg::OP_W-wrd_pkg::WORD_W){1'b0}}, den_w}
                            << (wrd_pkg::OP_W - wrd_pkg::WORD_W));
            shl_carry_in = rem_w[wrd_pkg::WORD_W-1];
            borrow_in    = sub[wrd_pkg::WORD_W];
            if (last_step) begin
               wrd_idx_in = '0;
               bit_cnt_in = bit_cnt_ff - 1'b1;
               num_ff_in  = num_ff << 1;
               quo_ff_in  = {quo_ff[wrd_pkg::OP_W-2:0], take};
               if (take) begin
                  rem_ff_in = (dif_ff >> wrd_pkg::WORD_W)
                            | ({{(wrd_pkg::OP_W-wrd_pkg::WORD_W){1'b0}},
                                sub[wrd_pkg::WORD_W-1:0]}
                               << (wrd_pkg::OP_W - wrd_pkg::WORD_W));
               end else begin
                  rem_ff_in = (shf_ff >> wrd_pkg::WORD_W)
                            | ({{(wrd_pkg::OP_W-wrd_pkg::WORD_W){1'b0}}, shifted}
                               << (wrd_pkg::OP_W - wrd_pkg::WORD_W));
               end
            end else begin
               wrd_idx_in = wrd_idx_ff + 1'b1;
               rem_ff_in  = rem_ff >> wrd_pkg::WORD_W;
               shf_ff_in  = (shf_ff >> wrd_pkg::WORD_W)
                          | ({{(wrd_pkg::OP_W-wrd_pkg::WORD_W){1'b0}}, shifted}
                             << (wrd_pkg::OP_W - wrd_pkg::WORD_W));
               dif_ff_in  = (dif_ff >> wrd_pkg::WORD_W)
                          | ({{(wrd_pkg::OP_W-wrd_pkg::WORD_W){1'b0}},
                              sub[wrd_pkg::WORD_W-1:0]}
                             << (wrd_pkg::OP_W - wrd_pkg::WORD_W));
            end
         end
         wrd_pkg::ST_DRAIN: begin
            if (rsp_xfer) begin
               quo_ff_in  = quo_ff >> wrd_pkg::WORD_W;
               rem_ff_in  = rem_ff >> wrd_pkg::WORD_W;
               wrd_idx_in = last_step ? '0 : wrd_idx_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wrd_pkg::ST_IDLE;
         wrd_idx_ff   <= '0;
         bit_cnt_ff   <= '0;
         shl_carry_ff <= 1'b0;
         borrow_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wrd_idx_ff   <= wrd_idx_in;
         bit_cnt_ff   <= bit_cnt_in;
         shl_carry_ff <= shl_carry_in;
         borrow_ff    <= borrow_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_ff_in;
      den_ff <= den_ff_in;
      rem_ff <= rem_ff_in;
      quo_ff <= quo_ff_in;
      shf_ff <= shf_ff_in;
      dif_ff <= dif_ff_in;
   end

   `WRD_ASSERT_NOW(a_start_when_idle, start_op, idle, "start while engine busy")
   `WRD_ASSERT_NOW(a_no_rsp_when_idle, idle, !rsp.valid, "result shown while idle")
   `WRD_ASSERT_NEXT(a_run_to_drain, (state_ff == wrd_pkg::ST_RUN) && last_step && last_bit,
      rsp.valid && (wrd_idx_ff == '0), "division did not hand over to drain")
   `WRD_ASSERT_NEXT(a_drain_done, rsp_xfer && rsp.payload.end_of_result, idle,
      "engine not idle after last result transfer")

endmodule

FILE: rtl/core/wide_restoring_divider.sv
// Top level of the wide restoring divider: operand word stores, load position and engine.
// Depends on wrd_pkg, wrd_req_if, wrd_rsp_if and wrd_divcore.
//
//   channel   dir  handshake          payload
//   req_chan  in   valid/ready        dividend_word, divisor_word, final_word
//   rsp_chan  out  valid/ready        quotient_word, remainder_word, end_of_result
//
// Operand word pairs are accepted while the engine is idle. The final word starts the
// engine, which does one 32-bit subtract per cycle; each quotient bit is one pass of the
// word-serial remainder loop over all WORDS words of the remainder.
// WORDS result transfers follow, one per cycle while rsp_chan.ready is high.
// req_chan.ready is low from after the final transfer until after the last result transfer.
// Reset is synchronous; the operand stores are not cleared and never read unwritten.
module wide_restoring_divider (
   input  logic      clock,
   input  logic      reset,
   wrd_req_if.sink   req_chan,
   wrd_rsp_if.source rsp_chan
);

   logic [wrd_pkg::WORD_W-1:0] div_store_ff [wrd_pkg::WORDS];
   logic [wrd_pkg::WORD_W-1:0] dsr_store_ff [wrd_pkg::WORDS];
   logic [wrd_pkg::POS_W-1:0]  load_pos_ff, load_pos_in;
   logic [wrd_pkg::POS_W-1:0]  pos_next;
   logic [wrd_pkg::OP_W-1:0]   num_vec;
   logic [wrd_pkg::OP_W-1:0]   den_vec;
   logic                       room;
   logic                       req_xfer;
   logic                       start_op;
   logic                       core_idle;

   assign req_chan.ready = core_idle;
   assign req_xfer       = req_chan.valid & req_chan.ready;
   assign room           = (load_pos_ff < wrd_pkg::WORDS_POS);
   assign pos_next       = load_pos_ff + {{(wrd_pkg::POS_W-1){1'b0}}, room};
   assign start_op       = req_xfer & req_chan.payload.final_word;

   // operand as seen after this transfer; unloaded positions read as zero
   always_comb begin
      for (int k = 0; k < wrd_pkg::WORDS; k++) begin
         if (room && (load_pos_ff == k[wrd_pkg::POS_W-1:0])) begin
            num_vec[k*wrd_pkg::WORD_W +: wrd_pkg::WORD_W] = req_chan.payload.dividend_word;
            den_vec[k*wrd_pkg::WORD_W +: wrd_pkg::WORD_W] = req_chan.payload.divisor_word;
         end else if (k[wrd_pkg::POS_W-1:0] < pos_next) begin
            num_vec[k*wrd_pkg::WORD_W +: wrd_pkg::WORD_W] = div_store_ff[k];
            den_vec[k*wrd_pkg::WORD_W +: wrd_pkg::WORD_W] = dsr_store_ff[k];
         end else begin
            num_vec[k*wrd_pkg::WORD_W +: wrd_pkg::WORD_W] = '0;
            den_vec[k*wrd_pkg::WORD_W +: wrd_pkg::WORD_W] = '0;
         end
      end
   end

   always_comb begin
      load_pos_in = load_pos_ff;
      priority if (start_op) begin
         load_pos_in = '0;
      end else if (req_xfer) begin
         load_pos_in = pos_next;
      end else begin
         load_pos_in = load_pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_pos_ff <= '0;
      end else begin
         load_pos_ff <= load_pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer && room) begin
         div_store_ff[load_pos_ff[wrd_pkg::WIDX_W-1:0]] <= req_chan.payload.dividend_word;
         dsr_store_ff[load_pos_ff[wrd_pkg::WIDX_W-1:0]] <= req_chan.payload.divisor_word;
      end
   end

   wrd_divcore u_divcore (
      .clock    (clock),
      .reset    (reset),
      .start_op (start_op),
      .num_in   (num_vec),
      .den_in   (den_vec),
      .idle     (core_idle),
      .rsp      (rsp_chan)
   );

endmodule
